### design/mqrb_pkg.sv
// ----------------------------------------------------------------------------
// mqrb_pkg
// Shared types and constants of the multi-queue ring buffer.
// ----------------------------------------------------------------------------
package mqrb_pkg;

	localparam int S_TDATA_W = 72;
	localparam int S_TUSER_W = 7;
	localparam int M_TDATA_W = 80;
	localparam int M_TUSER_W = 2;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;

	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_PEEK  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FLAG  = 2'd1,
		STAT_BADID = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_QRD  = 4'b0010,
		S_ERD  = 4'b0100,
		S_DONE = 4'b1000
	} fsm_t;

	localparam logic       REG_QUEUES   = 1'b0;
	localparam logic       REG_CAPACITY = 1'b1;
	localparam logic [8:0] CAPACITY_RST = 9'd256;

endpackage

### design/multi_queue_ring_buffer.sv
// ----------------------------------------------------------------------------
// multi_queue_ring_buffer
// Several circular FIFOs in one entry memory, with overwrite of the oldest.
// ----------------------------------------------------------------------------
// One command is in work at a time. A wrong queue id goes from accept
// straight to the result state; push, clear and a pop or peek on an empty
// queue first read the queue-state memory; a pop or peek that finds an entry
// then also reads the entry memory. Both memories have registered read data.
// The result sits in an output register, so the next command is taken while
// a result waits. Queue state comes out of reset as empty through one valid
// bit per queue; no clearing pass runs.
module multi_queue_ring_buffer #(
	parameter int NUM_QUEUES    = 32,
	parameter int QUEUE_DEPTH   = 256,
	parameter int PAYLOAD_BYTES = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mqrb_pkg::APB_AW-1:0]     paddr,
	input  logic [mqrb_pkg::APB_DW-1:0]     pwdata,
	output logic [mqrb_pkg::APB_DW-1:0]     prdata,
	output logic                            pready,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// payload [63:0], data_length [67:64], zero [71:68]
	input  logic [mqrb_pkg::S_TDATA_W-1:0]  s_tdata,
	// command [1:0], queue_id [6:2]
	input  logic [mqrb_pkg::S_TUSER_W-1:0]  s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// payload_out [63:0], length_out [67:64], fill_count [76:68],
	// is_full [77], zero [79:78]
	output logic [mqrb_pkg::M_TDATA_W-1:0]  m_tdata,
	// status [1:0]
	output logic [mqrb_pkg::M_TUSER_W-1:0]  m_tuser
);

	import mqrb_pkg::*;

	localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PW  = $clog2(QUEUE_DEPTH);
	localparam int CW  = $clog2(QUEUE_DEPTH + 1);
	localparam int EW  = (PW + 1 > 9) ? PW + 1 : 9;
	localparam int DW  = 8 * PAYLOAD_BYTES;
	localparam int QSW = CW + 2 * PW;
	localparam int EAW = QW + PW;
	localparam int ESW = DW + 4;

	fsm_t             state_q;
	logic [5:0]       queues_q;
	logic [8:0]       capacity_q;
	logic [NUM_QUEUES-1:0] qvalid_q;
	logic             m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic [M_TUSER_W-1:0] m_tuser_q;

	cmd_t             cmd_q;
	logic [QW-1:0]    qidx_q;
	logic [DW-1:0]    pay_q;
	logic [3:0]       len_q;
	status_t          res_status_q;
	logic [63:0]      res_pay_q;
	logic [3:0]       res_len_q;
	logic [8:0]       res_fill_q;
	logic             res_full_q;

	logic             accept;
	logic             out_free;
	cmd_t             in_cmd;
	logic [4:0]       in_qid;
	logic [3:0]       in_len;
	logic [3:0]       in_len_sat;
	logic [DW-1:0]    in_mask;
	logic             in_bad;

	logic             q_re;
	logic             q_we;
	logic [QSW-1:0]   q_rdata;
	logic [QSW-1:0]   q_wdata;
	logic [QSW-1:0]   qv;
	logic             e_re;
	logic             e_we;
	logic [ESW-1:0]   e_rdata;

	logic [PW-1:0]    wp;
	logic [PW-1:0]    rp;
	logic [CW-1:0]    cnt;
	logic [PW-1:0]    wp_step;
	logic [PW-1:0]    rp_step;
	logic [PW-1:0]    wp_n;
	logic [PW-1:0]    rp_n;
	logic [CW-1:0]    cnt_n;
	logic [8:0]       cap_nz;
	logic [EW-1:0]    cap_eff;
	logic             full_now;
	logic             full_n;
	status_t          st;
	logic             go_erd;
	logic             upd_q;
	logic             wr_e;
	logic             rd_e;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CAPACITY) ? {23'b0, capacity_q} : {26'b0, queues_q};

	assign in_cmd = cmd_t'(s_tuser[1:0]);
	assign in_qid = s_tuser[6:2];
	assign in_len = s_tdata[67:64];
	assign in_len_sat = (in_len > 4'(PAYLOAD_BYTES)) ? 4'(PAYLOAD_BYTES) : in_len;
	assign in_bad = ({1'b0, in_qid} >= queues_q) || (7'(in_qid) >= 7'(NUM_QUEUES));

	always_comb begin
		for (int i = 0; i < PAYLOAD_BYTES; i++) begin
			in_mask[8*i +: 8] = (4'(i) < in_len_sat) ? 8'hFF : 8'h00;
		end
	end

	assign cap_nz  = (capacity_q == 9'd0) ? 9'd1 : capacity_q;
	assign cap_eff = (EW'(cap_nz) > EW'(QUEUE_DEPTH)) ? EW'(QUEUE_DEPTH) : EW'(cap_nz);

	assign qv       = qvalid_q[qidx_q] ? q_rdata : '0;
	assign wp       = qv[PW-1:0];
	assign rp       = qv[2*PW-1:PW];
	assign cnt      = qv[QSW-1:2*PW];
	assign full_now = EW'(cnt) >= cap_eff;
	assign wp_step  = ((EW'(wp) + EW'(1)) >= cap_eff) ? '0 : wp + PW'(1);
	assign rp_step  = ((EW'(rp) + EW'(1)) >= cap_eff) ? '0 : rp + PW'(1);

	always_comb begin
		wp_n   = wp;
		rp_n   = rp;
		cnt_n  = cnt;
		st     = STAT_OK;
		upd_q  = 1'b0;
		wr_e   = 1'b0;
		rd_e   = 1'b0;
		go_erd = 1'b0;
		case (cmd_q)
			CMD_PUSH: begin
				wr_e  = 1'b1;
				upd_q = 1'b1;
				wp_n  = wp_step;
				if (full_now) begin
					st   = STAT_FLAG;
					rp_n = rp_step;
				end else begin
					cnt_n = cnt + CW'(1);
				end
			end
			CMD_POP, CMD_PEEK: begin
				if (cnt == '0) begin
					st = STAT_FLAG;
				end else begin
					rd_e   = 1'b1;
					go_erd = 1'b1;
					if (cmd_q == CMD_POP) begin
						upd_q = 1'b1;
						rp_n  = rp_step;
						cnt_n = cnt - CW'(1);
					end
				end
			end
			CMD_CLEAR: begin
				upd_q = 1'b1;
				wp_n  = '0;
				rp_n  = '0;
				cnt_n = '0;
			end
			default: begin
				upd_q = 1'b0;
			end
		endcase
	end

	assign full_n  = EW'(cnt_n) >= cap_eff;
	assign q_re    = accept && !in_bad;
	assign q_we    = (state_q == S_QRD) && upd_q;
	assign q_wdata = {cnt_n, rp_n, wp_n};
	assign e_we    = (state_q == S_QRD) && wr_e;
	assign e_re    = (state_q == S_QRD) && rd_e;

	mqrb_ram #(
		.WIDTH (QSW),
		.DEPTH (NUM_QUEUES)
	) u_qstate (
		.clk   (clk),
		.we    (q_we),
		.waddr (qidx_q),
		.wdata (q_wdata),
		.re    (q_re),
		.raddr (QW'(in_qid)),
		.rdata (q_rdata)
	);

	mqrb_ram #(
		.WIDTH (ESW),
		.DEPTH (2 ** EAW)
	) u_entries (
		.clk   (clk),
		.we    (e_we),
		.waddr ({qidx_q, wp}),
		.wdata ({len_q, pay_q}),
		.re    (e_re),
		.raddr ({qidx_q, rp}),
		.rdata (e_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			queues_q   <= '0;
			capacity_q <= CAPACITY_RST;
			qvalid_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_CAPACITY) begin
					capacity_q <= pwdata[8:0];
				end else begin
					queues_q <= pwdata[5:0];
				end
			end
			if (q_we) begin
				qvalid_q[qidx_q] <= 1'b1;
			end
			if (state_q == S_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= in_bad ? S_DONE : S_QRD;
					end
				end
				S_QRD: begin
					state_q <= go_erd ? S_ERD : S_DONE;
				end
				S_ERD: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q        <= in_cmd;
			qidx_q       <= QW'(in_qid);
			pay_q        <= s_tdata[DW-1:0] & in_mask;
			len_q        <= in_len_sat;
			res_status_q <= in_bad ? STAT_BADID : STAT_OK;
			res_pay_q    <= '0;
			res_len_q    <= '0;
			res_fill_q   <= '0;
			res_full_q   <= 1'b0;
		end
		if (state_q == S_QRD) begin
			res_status_q <= st;
			res_fill_q   <= 9'(cnt_n);
			res_full_q   <= full_n;
		end
		if (state_q == S_ERD) begin
			res_len_q <= e_rdata[ESW-1:DW];
			res_pay_q <= (cmd_q == CMD_POP) ? 64'(e_rdata[DW-1:0]) : '0;
		end
		if (state_q == S_DONE && out_free) begin
			m_tdata_q <= {2'b0, res_full_q, res_fill_q, res_len_q, res_pay_q};
			m_tuser_q <= res_status_q;
		end
	end

endmodule

### design/mqrb_ram.sv
// ----------------------------------------------------------------------------
// mqrb_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module mqrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/mqrb_check.sv
// ----------------------------------------------------------------------------
// mqrb_check
// Port-level checks of the multi-queue ring buffer, bound to the top level.
// ----------------------------------------------------------------------------
module mqrb_check (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [mqrb_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [mqrb_pkg::M_TUSER_W-1:0] m_tuser
);

	import mqrb_pkg::*;

	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second word taken while a command is in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result word changed");

	a_badid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STAT_BADID) |-> m_tdata == '0)
		else $error("wrong-id result carries data");

	a_flag_nodata: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STAT_FLAG) |-> m_tdata[67:0] == '0)
		else $error("overflow or empty result carries entry data");

	a_full_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[77] |-> m_tdata[76:68] != '0)
		else $error("full flag with zero fill count");

endmodule

bind multi_queue_ring_buffer mqrb_check u_mqrb_check (.*);
